@@ sv/ibd_pkg.sv @@
// ibd_pkg: shared types, codes and reset values for the integrator button debouncer
// used by ibd_cfg, ibd_core and integrator_button_debouncer; no dependencies
`timescale 1ns / 1ps

package ibd_pkg;

  localparam int THR_W  = 8;
  localparam int ID_W   = 16;
  localparam int CODE_W = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_INIT   = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;

  // edge modes
  localparam logic [1:0] MODE_FALLING = 2'd0;
  localparam logic [1:0] MODE_RISING  = 2'd1;
  localparam logic [1:0] MODE_BOTH    = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_LOW = 3'd1;
  localparam logic [IDX_W-1:0] REG_EDGE_MODE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_EVENT_ID   = 3'd3;
  localparam logic [IDX_W-1:0] REG_EVENT_CODE = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]  RST_THRESHOLD  = 8'h06;
  localparam logic              RST_ACTIVE_LOW = 1'b1;
  localparam logic [1:0]        RST_EDGE_MODE  = MODE_FALLING;
  localparam logic [ID_W-1:0]   RST_EVENT_ID   = 16'h0100;
  localparam logic [CODE_W-1:0] RST_EVENT_CODE = 32'h0000_0001;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic              active_low;
    logic [1:0]        edge_mode;
    logic [ID_W-1:0]   event_id;
    logic [CODE_W-1:0] event_code;
  } cfg_t;

  typedef struct packed {
    logic [THR_W-1:0] count;
    logic             stable_pressed;
    logic             sampling;
    logic             initialized;
  } state_t;

  typedef struct packed {
    logic              event_valid;
    logic              event_pressed;
    logic [ID_W-1:0]   event_type;
    logic [CODE_W-1:0] event_payload_code;
    logic              debounced_pressed;
    logic              sampling_active;
  } result_t;

endpackage

@@ sv/integrator_button_debouncer.sv @@
// integrator_button_debouncer: top level, input register, debouncer state, result register
// depends on ibd_pkg, ibd_cfg, ibd_core
// an accepted input transaction passes the input register and then the result register before it shows on m_tvalid
// throughput: one item per cycle while m_tready holds; the state update in ibd_core is combinational
// the input register can take a new item while a finished result in the result register waits on m_tready
// reset (rst, synchronous): integrator, flags and valids cleared, registers to defaults
`timescale 1ns / 1ps

module integrator_button_debouncer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ibd_pkg::IDX_W-1:0] cfg_index,
  input  logic [ibd_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,  // [0] pin_high, [7:1] zero
  input  logic [1:0]                s_tuser,  // [1:0] operation
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [0] event_valid, [1] event_pressed, [17:2] event_type,
  // [49:18] event_payload_code, [50] debounced_pressed, [51] sampling_active, [55:52] zero
  output logic [55:0]               m_tdata
);

  ibd_pkg::cfg_t    cfg;
  ibd_pkg::state_t  state;
  ibd_pkg::state_t  state_next;
  ibd_pkg::result_t res_next;
  ibd_pkg::result_t res;

  logic       in_valid;
  logic [1:0] in_op;
  logic       in_pin;
  logic       load;

  ibd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ibd_core u_core (
    .cfg        (cfg),
    .state      (state),
    .op         (in_op),
    .pin_high   (in_pin),
    .state_next (state_next),
    .result     (res_next)
  );

  // item in the input register moves on when the result slot is free or draining
  assign load     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_pin <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

  assign m_tdata = {4'b0000, res.sampling_active, res.debounced_pressed,
                    res.event_payload_code, res.event_type,
                    res.event_pressed, res.event_valid};

`ifndef SYNTHESIS
  // a tick before initialization leaves the debounced state alone
  a_tick_uninit: assert property (@(posedge clk) disable iff (rst)
    load && in_op == ibd_pkg::OP_TICK && !state.initialized
      |=> $stable(state.stable_pressed) && $stable(state.count))
    else $error("tick before initialization changed the debouncer state");

  // a pin change notice always leaves the sampling flag raised
  a_change_sets: assert property (@(posedge clk) disable iff (rst)
    load && in_op == ibd_pkg::OP_CHANGE |=> state.sampling && res.sampling_active)
    else $error("pin change did not raise the sampling flag");

  // an event always goes with a switch of the debounced state
  a_event_switch: assert property (@(posedge clk) disable iff (rst)
    load && res_next.event_valid
      |=> state.stable_pressed != $past(state.stable_pressed)
          && res.event_pressed == state.stable_pressed)
    else $error("event emitted without a debounced state switch");

  // the integrator never counts past the threshold from at or below it
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    load && state.count <= cfg.threshold |=> state.count <= $past(cfg.threshold))
    else $error("integrator passed the threshold");
`endif

endmodule

@@ sv/ibd_cfg.sv @@
// ibd_cfg: configuration register file of the debouncer, write only
// depends on ibd_pkg
`timescale 1ns / 1ps

module ibd_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [ibd_pkg::IDX_W-1:0] index,
  input  logic [ibd_pkg::CFG_W-1:0] data,
  output ibd_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= ibd_pkg::RST_THRESHOLD;
      cfg.active_low <= ibd_pkg::RST_ACTIVE_LOW;
      cfg.edge_mode  <= ibd_pkg::RST_EDGE_MODE;
      cfg.event_id   <= ibd_pkg::RST_EVENT_ID;
      cfg.event_code <= ibd_pkg::RST_EVENT_CODE;
    end else if (we) begin
      unique case (index)
        ibd_pkg::REG_THRESHOLD:  cfg.threshold  <= data[ibd_pkg::THR_W-1:0];
        ibd_pkg::REG_ACTIVE_LOW: cfg.active_low <= data[0];
        ibd_pkg::REG_EDGE_MODE:  cfg.edge_mode  <= data[1:0];
        ibd_pkg::REG_EVENT_ID:   cfg.event_id   <= data[ibd_pkg::ID_W-1:0];
        ibd_pkg::REG_EVENT_CODE: cfg.event_code <= data[ibd_pkg::CODE_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

endmodule

@@ sv/ibd_core.sv @@
// ibd_core: integrator update, debounced state switch and event qualification
// combinational; depends on ibd_pkg
`timescale 1ns / 1ps

module ibd_core (
  input  ibd_pkg::cfg_t    cfg,
  input  ibd_pkg::state_t  state,
  input  logic [1:0]       op,
  input  logic             pin_high,
  output ibd_pkg::state_t  state_next,
  output ibd_pkg::result_t result
);

  logic                      level;
  logic                      press_ok;
  logic                      release_ok;
  logic [ibd_pkg::THR_W-1:0] count_step;
  logic                      emit;
  logic                      emit_pressed;

  assign level = cfg.active_low ? ~pin_high : pin_high;

  assign press_ok = (cfg.edge_mode == ibd_pkg::MODE_BOTH)
                 || (cfg.active_low && cfg.edge_mode == ibd_pkg::MODE_FALLING)
                 || (!cfg.active_low && cfg.edge_mode == ibd_pkg::MODE_RISING);
  assign release_ok = (cfg.edge_mode == ibd_pkg::MODE_BOTH)
                   || (cfg.active_low && cfg.edge_mode == ibd_pkg::MODE_RISING)
                   || (!cfg.active_low && cfg.edge_mode == ibd_pkg::MODE_FALLING);

  // saturating integrator
  always_comb begin
    count_step = state.count;
    if (level) begin
      if (state.count < cfg.threshold) count_step = state.count + 1'b1;
    end else begin
      if (state.count != '0) count_step = state.count - 1'b1;
    end
  end

  always_comb begin
    state_next   = state;
    emit         = 1'b0;
    emit_pressed = 1'b0;
    priority if (op == ibd_pkg::OP_INIT) begin
      state_next.stable_pressed = level;
      state_next.count          = level ? cfg.threshold : '0;
      state_next.sampling       = 1'b0;
      state_next.initialized    = 1'b1;
    end else if (op == ibd_pkg::OP_CHANGE) begin
      state_next.sampling = 1'b1;
    end else if (op == ibd_pkg::OP_TICK && state.initialized) begin
      state_next.count = count_step;
      if (count_step >= cfg.threshold) begin
        if (!state.stable_pressed) begin
          state_next.stable_pressed = 1'b1;
          emit         = press_ok;
          emit_pressed = press_ok;
        end
        if (level) state_next.sampling = 1'b0;
      end else if (count_step == '0) begin
        if (state.stable_pressed) begin
          state_next.stable_pressed = 1'b0;
          emit = release_ok;
        end
        if (!level) state_next.sampling = 1'b0;
      end
    end
  end

  always_comb begin
    result.event_valid        = emit;
    result.event_pressed      = emit_pressed;
    result.event_type         = emit ? cfg.event_id : '0;
    result.event_payload_code = emit ? cfg.event_code : '0;
    result.debounced_pressed  = state_next.stable_pressed;
    result.sampling_active    = state_next.sampling;
  end

endmodule
